// ===== hw/rtl/ascii_integer_stream_parser_macros.svh =====
// ----------------------------------------------------------------------------
// ascii_integer_stream_parser assertion macros
// Property wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASCII_INTEGER_STREAM_PARSER_MACROS_SVH
`define ASCII_INTEGER_STREAM_PARSER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define AISP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked out of reset
`define AISP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AISP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AISP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/aisp_pkg.sv =====
// ----------------------------------------------------------------------------
// aisp_pkg
// Shared types, codes and widths of the integer stream parser.
// ----------------------------------------------------------------------------
package aisp_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int VALUE_W         = 32;
  localparam int INDEX_W         = 16;
  localparam int CFG_DATA_W      = 16;

  // Input actions
  typedef enum logic [1:0] {
    ACT_DATA  = 2'd0,
    ACT_END   = 2'd1,
    ACT_START = 2'd2
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_VALUE = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BINARY_MODE = 2'd0,
    REG_SHORT_MODE  = 2'd1,
    REG_MAX_COUNT   = 2'd2
  } reg_index_t;

  // Parser phases, one-hot
  typedef enum logic [5:0] {
    PH_FINISHED = 6'b000001,
    PH_SKIP     = 6'b000010,
    PH_COMMENT  = 6'b000100,
    PH_MINUS    = 6'b001000,
    PH_DIGITS   = 6'b010000,
    PH_BINARY   = 6'b100000
  } phase_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Truncate to 16 bits with sign extension in short mode
  function automatic logic [VALUE_W-1:0] shape_value(input logic [VALUE_W-1:0] v,
                                                     input logic short_mode);
    shape_value = short_mode ? {{16{v[15]}}, v[15:0]} : v;
  endfunction

endpackage

// ===== hw/rtl/aisp_if.sv =====
// ----------------------------------------------------------------------------
// aisp_if
// Valid/ready channels for input bytes and parsed results.
// ----------------------------------------------------------------------------
interface aisp_in_if;
  import aisp_pkg::*;

  logic       valid;
  logic       ready;
  action_t    action;
  logic [7:0] byte_in;

  modport source (output valid, output action, output byte_in, input ready);
  modport sink   (input valid, input action, input byte_in, output ready);
endinterface

interface aisp_out_if;
  import aisp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  value;
  status_t                    status;
  logic                       last;
  logic        [INDEX_W-1:0]  value_index;

  modport source (output valid, output value, output status, output last,
                  output value_index, input ready);
  modport sink   (input valid, input value, input status, input last,
                  input value_index, output ready);
endinterface

// ===== hw/rtl/ascii_integer_stream_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_integer_stream_parser: a result is registered the cycle after its input.
// Throughput one byte per cycle unless a held result stalls input; single parse step.
// Synchronous active-low reset: phase finished; counters, config, output valid cleared.
// ----------------------------------------------------------------------------
`include "ascii_integer_stream_parser_macros.svh"

module ascii_integer_stream_parser #(
  parameter int COUNT_WIDTH = aisp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  aisp_pkg::reg_index_t             cfg_index,
  input  logic [aisp_pkg::CFG_DATA_W-1:0]  cfg_data,
  aisp_in_if.sink                          in_ch,
  aisp_out_if.source                       out_ch
);
  import aisp_pkg::*;

  // Configuration
  logic                   binary_mode_r;
  logic                   short_mode_r;
  logic [CFG_DATA_W-1:0]  max_count_r;

  // Parser state
  phase_t                 phase_r, phase_nxt;
  logic [VALUE_W-1:0]     acc_r, acc_nxt;
  logic                   neg_r, neg_nxt;
  logic [COUNT_WIDTH-1:0] vd_r, vd_nxt;
  logic [1:0]             bpos_r, bpos_nxt;

  // Output register
  logic                   out_valid_r;
  logic [VALUE_W-1:0]     out_value_r;
  status_t                out_status_r;
  logic                   out_last_r;
  logic [INDEX_W-1:0]     out_index_r;

  // Step results
  logic                   accept;
  logic                   res_valid;
  logic [VALUE_W-1:0]     res_value;
  status_t                res_status;
  logic                   res_last;
  logic                   do_deliver;
  logic                   force_last;
  logic [VALUE_W-1:0]     deliver_raw;
  logic                   do_finish;
  status_t                finish_status;

  logic [7:0]             c;
  logic                   is_digit;
  logic [3:0]             digit;
  logic [VALUE_W-1:0]     signed_acc;
  logic [VALUE_W-1:0]     acc_times10;
  logic [VALUE_W-1:0]     acc_shift;
  logic [1:0]             bpos_inc;
  logic [COUNT_WIDTH-1:0] vd_inc;
  logic [31:0]            mc_ext;
  logic [COUNT_WIDTH-1:0] mc_cmp;
  logic                   hit_count;
  logic [31:0]            vd_ext;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Datapath helpers
  assign c           = in_ch.byte_in;
  assign is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit       = 4'(c - CH_ZERO);
  assign signed_acc  = neg_r ? (VALUE_W'(0) - acc_r) : acc_r;
  assign acc_times10 = (acc_r << 3) + (acc_r << 1) + VALUE_W'(digit);
  assign acc_shift   = {acc_r[VALUE_W-9:0], c};
  assign bpos_inc    = bpos_r + 2'd1;
  assign vd_inc      = vd_r + COUNT_WIDTH'(1);
  assign mc_ext      = 32'(max_count_r);
  assign mc_cmp      = mc_ext[COUNT_WIDTH-1:0];
  assign hit_count   = (vd_inc == mc_cmp);

  // Parse one transaction
  always_comb begin
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    vd_nxt        = vd_r;
    bpos_nxt      = bpos_r;
    do_deliver    = 1'b0;
    force_last    = 1'b0;
    deliver_raw   = signed_acc;
    do_finish     = 1'b0;
    finish_status = ST_EMPTY;

    if (accept) begin
      if (in_ch.action == ACT_START) begin
        acc_nxt  = '0;
        neg_nxt  = 1'b0;
        vd_nxt   = '0;
        bpos_nxt = '0;
        if (mc_cmp == '0) begin
          do_finish = 1'b1;
        end else begin
          phase_nxt = binary_mode_r ? PH_BINARY : PH_SKIP;
        end
      end else if (in_ch.action == ACT_END && phase_r != PH_FINISHED) begin
        if (phase_r == PH_DIGITS) begin
          do_deliver = 1'b1;
          force_last = 1'b1;
        end else if (phase_r == PH_MINUS) begin
          do_finish     = 1'b1;
          finish_status = ST_ERROR;
        end else begin
          do_finish = 1'b1;
        end
      end else if (in_ch.action == ACT_DATA) begin
        unique case (phase_r)
          PH_FINISHED: begin
          end
          PH_BINARY: begin
            acc_nxt  = acc_shift;
            bpos_nxt = bpos_inc;
            if (bpos_inc == 2'd0 || (short_mode_r && bpos_inc >= 2'd2)) begin
              do_deliver  = 1'b1;
              deliver_raw = acc_shift;
            end
          end
          PH_COMMENT: begin
            if (c == CH_LF) phase_nxt = PH_SKIP;
          end
          PH_SKIP: begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
            end else if (c == CH_HASH) begin
              phase_nxt = PH_COMMENT;
            end else if (c == CH_MINUS) begin
              neg_nxt   = 1'b1;
              phase_nxt = PH_MINUS;
            end else if (is_digit) begin
              acc_nxt   = VALUE_W'(digit);
              phase_nxt = PH_DIGITS;
            end else begin
              do_finish     = 1'b1;
              finish_status = ST_ERROR;
            end
          end
          PH_MINUS: begin
            if (is_digit) begin
              acc_nxt   = VALUE_W'(digit);
              phase_nxt = PH_DIGITS;
            end else begin
              do_finish     = 1'b1;
              finish_status = ST_ERROR;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              acc_nxt = acc_times10;
            end else begin
              do_deliver = 1'b1;
            end
          end
          default: begin
            phase_nxt = PH_FINISHED;
          end
        endcase
      end
    end

    // Deliver a value or close the read
    res_valid  = do_deliver || do_finish;
    res_value  = '0;
    res_status = finish_status;
    res_last   = 1'b1;
    if (do_deliver) begin
      vd_nxt     = vd_inc;
      acc_nxt    = '0;
      neg_nxt    = 1'b0;
      bpos_nxt   = '0;
      res_value  = shape_value(deliver_raw, short_mode_r);
      res_status = ST_VALUE;
      res_last   = force_last || hit_count;
      if (res_last) begin
        phase_nxt = PH_FINISHED;
      end else if (phase_r != PH_BINARY) begin
        phase_nxt = PH_SKIP;
      end
    end else if (do_finish) begin
      phase_nxt = PH_FINISHED;
    end
  end

  assign vd_ext = 32'(vd_nxt);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      binary_mode_r <= 1'b0;
      short_mode_r  <= 1'b0;
      max_count_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BINARY_MODE: binary_mode_r <= cfg_data[0];
        REG_SHORT_MODE:  short_mode_r  <= cfg_data[0];
        REG_MAX_COUNT:   max_count_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Advance parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FINISHED;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      vd_r    <= '0;
      bpos_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      vd_r    <= vd_nxt;
      bpos_r  <= bpos_nxt;
    end
  end

  // Hold the result until the output transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
      out_last_r   <= res_last;
      out_index_r  <= vd_ext[INDEX_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.value       = out_value_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.value_index = out_index_r;

  // Checks
  `AISP_ASSERT_IMP(a_status_ends_read, clk, rst_n,
    out_valid_r && out_status_r != ST_VALUE, out_last_r)
  `AISP_ASSERT_NXT(a_last_finishes, clk, rst_n,
    accept && res_valid && res_last, phase_r == PH_FINISHED)
  `AISP_ASSERT_NXT(a_start_clears_count, clk, rst_n,
    accept && in_ch.action == ACT_START, vd_r == '0)
  `AISP_ASSERT_IMP(a_value_index_nonzero, clk, rst_n,
    out_valid_r && out_status_r == ST_VALUE, out_index_r != '0)

endmodule

// ===== sim/ascii_integer_stream_parser_tb.sv =====
// ----------------------------------------------------------------------------
// ascii_integer_stream_parser_tb
// Drives bytes, end markers and read starts into the integer stream parser
// over valid/ready channels. Predicts each result in the testbench itself
// and compares every returned transaction field by field, in order.
// ----------------------------------------------------------------------------
module ascii_integer_stream_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aisp_pkg::*;

  localparam int          CYCLE_LIMIT  = 300000;
  localparam action_t     ACT_RESERVED = action_t'(2'd3);
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic               last;
    logic [INDEX_W-1:0] count_at;
  } parse_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  reg_index_t            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  aisp_in_if  in_ch ();
  aisp_out_if out_ch ();

  ascii_integer_stream_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predicted parser state and register copies
  logic               cfg_bin;
  logic               cfg_short;
  logic [15:0]        cfg_count;
  phase_t             rd_phase;
  logic [VALUE_W-1:0] acc_q;
  logic               neg_q;
  logic [INDEX_W-1:0] done_q;
  logic [1:0]         pos_q;

  parse_result_t pending_results[$];

  int          errors = 0;
  int          items_sent = 0;
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  int          hold_len = 0;
  int unsigned cycle_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: hold off for a requested stretch, else stall at random
  always @(negedge clk) begin
    if (hold_len != 0) begin
      out_ch.ready <= 1'b0;
      hold_len = hold_len - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic parse_result_t close_read(input status_t st);
    parse_result_t r;
    rd_phase   = PH_FINISHED;
    r.value    = '0;
    r.status   = st;
    r.last     = 1'b1;
    r.count_at = done_q;
    return r;
  endfunction

  function automatic parse_result_t take_value(input logic [VALUE_W-1:0] raw,
                                               input bit force_last);
    parse_result_t r;
    r.value    = cfg_short ? {{16{raw[15]}}, raw[15:0]} : raw;
    done_q     = done_q + 1'b1;
    r.status   = ST_VALUE;
    r.last     = force_last || (done_q == cfg_count);
    r.count_at = done_q;
    acc_q      = '0;
    neg_q      = 1'b0;
    pos_q      = '0;
    rd_phase   = r.last ? PH_FINISHED : ((rd_phase == PH_BINARY) ? PH_BINARY : PH_SKIP);
    return r;
  endfunction

  // Advance the predicted parser by one transaction; 1 when a result is due
  function automatic bit parse_step(input action_t act, input logic [7:0] c,
                                    output parse_result_t r);
    bit                 is_digit;
    logic [VALUE_W-1:0] signed_acc;
    int                 need;
    is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
    signed_acc = neg_q ? (32'd0 - acc_q) : acc_q;
    need       = cfg_short ? 2 : 4;
    r          = '0;
    if (act == ACT_START) begin
      acc_q  = '0;
      neg_q  = 1'b0;
      done_q = '0;
      pos_q  = '0;
      if (cfg_count == 16'd0) begin
        r = close_read(ST_EMPTY);
        return 1'b1;
      end
      rd_phase = cfg_bin ? PH_BINARY : PH_SKIP;
      return 1'b0;
    end
    if (act == ACT_RESERVED || rd_phase == PH_FINISHED) return 1'b0;
    if (act == ACT_END) begin
      case (rd_phase)
        PH_DIGITS: r = take_value(signed_acc, 1'b1);
        PH_MINUS:  r = close_read(ST_ERROR);
        default:   r = close_read(ST_EMPTY);
      endcase
      return 1'b1;
    end
    case (rd_phase)
      PH_BINARY: begin
        acc_q = {acc_q[23:0], c};
        pos_q = pos_q + 1'b1;
        if (pos_q == 2'd0 || int'(pos_q) >= need) begin
          r = take_value(acc_q, 1'b0);
          return 1'b1;
        end
      end
      PH_COMMENT: begin
        if (c == CH_LF) rd_phase = PH_SKIP;
      end
      PH_SKIP: begin
        if (c == CH_HASH) begin
          rd_phase = PH_COMMENT;
        end else if (c == CH_MINUS) begin
          neg_q    = 1'b1;
          rd_phase = PH_MINUS;
        end else if (is_digit) begin
          acc_q    = {24'd0, c - CH_ZERO};
          rd_phase = PH_DIGITS;
        end else if (c != CH_SPACE && c != CH_TAB && c != CH_LF) begin
          r = close_read(ST_ERROR);
          return 1'b1;
        end
      end
      PH_MINUS: begin
        if (is_digit) begin
          acc_q    = {24'd0, c - CH_ZERO};
          rd_phase = PH_DIGITS;
        end else begin
          r = close_read(ST_ERROR);
          return 1'b1;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          acc_q = acc_q * 32'd10 + {24'd0, c - CH_ZERO};
        end else begin
          r = take_value(signed_acc, 1'b0);
          return 1'b1;
        end
      end
      default: rd_phase = PH_FINISHED;
    endcase
    return 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Check each result transaction first, then predict from the input transaction
  always @(posedge clk) begin
    parse_result_t got;
    parse_result_t want;
    parse_result_t r;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.value, out_ch.status, out_ch.last, out_ch.value_index};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value %h status %0d",
                   $time, got.value, got.status);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("value", want.value, got.value);
          check_field("status", want.status, got.status);
          check_field("last", want.last, got.last);
          check_field("value_index", want.count_at, got.count_at);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (parse_step(in_ch.action, in_ch.byte_in, r)) pending_results.push_back(r);
      end
    end
  end

  // Offer one transaction from a falling edge and hold it until accepted
  task automatic send_item(input action_t act, input logic [7:0] b);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.byte_in <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(ACT_DATA, s[i]);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all three registers; only called while the parser is idle
  task automatic configure(input logic bin, input logic shrt, input logic [15:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BINARY_MODE;
    cfg_data  <= {15'($urandom), bin};
    @(negedge clk);
    cfg_index <= REG_SHORT_MODE;
    cfg_data  <= {15'($urandom), shrt};
    @(negedge clk);
    cfg_index <= REG_MAX_COUNT;
    cfg_data  <= count;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_bin   = bin;
    cfg_short = shrt;
    cfg_count = count;
  endtask

  // Reset defaults: finished and zero count, so only a start answers
  task automatic test_reset_state();
    send_item(ACT_DATA, 8'h41);
    send_item(ACT_END, 8'h00);
    send_item(ACT_RESERVED, 8'hFF);
    send_item(ACT_START, 8'h00);
    drain();
  endtask

  // Extremes, terminators, comments, errors and end-of-input cases
  task automatic test_text_cases();
    configure(1'b0, 1'b0, 16'd3);
    send_item(ACT_START, 8'h00);
    send_text("-2147483648 4294967295## c\n12-x");
    send_item(ACT_START, 8'h00);
    send_text("5\t-x");
    send_item(ACT_START, 8'h00);
    send_text("-");
    send_item(ACT_END, 8'h00);
    send_item(ACT_START, 8'h00);
    send_text("0 4");
    send_item(ACT_START, 8'h00);
    send_text("42");
    send_item(ACT_END, 8'h00);
    send_item(ACT_START, 8'h00);
    send_text("\n");
    send_item(ACT_END, 8'h00);
    send_item(ACT_START, 8'h00);
    send_text("z");
    drain();
  endtask

  // Big-endian words, a dropped partial word, and two-byte words
  task automatic test_binary_words();
    logic [7:0] long_bytes [7]  = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00};
    logic [7:0] short_bytes [4] = '{8'h80, 8'h00, 8'h7F, 8'hFF};
    configure(1'b1, 1'b0, 16'd2);
    send_item(ACT_START, 8'h00);
    foreach (long_bytes[i]) send_item(ACT_DATA, long_bytes[i]);
    send_item(ACT_END, 8'h00);
    drain();
    configure(1'b1, 1'b1, 16'd2);
    send_item(ACT_START, 8'h00);
    foreach (short_bytes[i]) send_item(ACT_DATA, short_bytes[i]);
    drain();
  endtask

  // Text values truncated to 16 bits
  task automatic test_short_values();
    configure(1'b0, 1'b1, 16'd2);
    send_item(ACT_START, 8'h00);
    send_text("70000 -32769 ");
    drain();
  endtask

  // Fill the parser against a held-off receiver, then pause until it empties
  task automatic test_backpressure();
    configure(1'b1, 1'b1, COUNT_MAX);
    @(posedge clk);
    hold_len = 150;
    @(negedge clk);
    send_item(ACT_START, 8'h00);
    repeat (40) send_item(ACT_DATA, 8'($urandom));
    send_item(ACT_END, 8'h00);
    drain();
  endtask

  // One text read of well-formed numbers with occasional noise
  task automatic text_read();
    int nd;
    send_item(ACT_START, 8'($urandom));
    repeat ($urandom_range(1, 8)) begin
      // separators and comments ahead of the number
      repeat ($urandom_range(0, 2)) begin
        case ($urandom_range(3))
          0: send_item(ACT_DATA, CH_SPACE);
          1: send_item(ACT_DATA, CH_TAB);
          2: send_item(ACT_DATA, CH_LF);
          default: begin
            send_item(ACT_DATA, CH_HASH);
            repeat ($urandom_range(0, 5)) send_item(ACT_DATA, 8'($urandom));
            send_item(ACT_DATA, CH_LF);
          end
        endcase
      end
      if ($urandom_range(19) == 0) send_item(ACT_DATA, 8'($urandom));
      if ($urandom_range(3) == 0) send_item(ACT_DATA, CH_MINUS);
      nd = ($urandom_range(15) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 10);
      repeat (nd) send_item(ACT_DATA, CH_ZERO + 8'($urandom_range(9)));
      // terminator, consumed with the number
      case ($urandom_range(9))
        0: send_item(ACT_DATA, CH_TAB);
        1: send_item(ACT_DATA, CH_LF);
        2: send_item(ACT_DATA, CH_HASH);
        3: send_item(ACT_DATA, CH_MINUS);
        4: send_item(ACT_DATA, 8'($urandom));
        default: send_item(ACT_DATA, CH_SPACE);
      endcase
    end
    case ($urandom_range(9))
      0: ; // leave the read open; the next start drops it
      1: begin
        send_item(ACT_RESERVED, 8'($urandom));
        send_item(ACT_END, 8'($urandom));
      end
      default: send_item(ACT_END, 8'($urandom));
    endcase
  endtask

  task automatic binary_read();
    send_item(ACT_START, 8'($urandom));
    repeat ($urandom_range(0, 14)) send_item(ACT_DATA, 8'($urandom));
    if ($urandom_range(7) != 0) send_item(ACT_END, 8'($urandom));
  endtask

  // Rounds of random settings, each followed by a few reads
  task automatic test_random_reads(input int n);
    int          stop;
    logic [15:0] count;
    stop = items_sent + n;
    while (items_sent < stop) begin
      drain();
      case ($urandom_range(19))
        0:       count = 16'd0;
        1:       count = COUNT_MAX;
        2:       count = 16'($urandom_range(7, 40));
        default: count = 16'($urandom_range(1, 6));
      endcase
      configure(1'($urandom_range(1)), 1'($urandom_range(1)), count);
      repeat ($urandom_range(1, 4)) begin
        if (cfg_bin) binary_read();
        else text_read();
      end
    end
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_DATA;
    in_ch.byte_in = 8'h00;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_BINARY_MODE;
    cfg_data      = '0;
    cfg_bin       = 1'b0;
    cfg_short     = 1'b0;
    cfg_count     = 16'd0;
    rd_phase      = PH_FINISHED;
    acc_q         = '0;
    neg_q         = 1'b0;
    done_q        = '0;
    pos_q         = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    src_idle_pct  = 14;
    sink_idle_pct = 65;
    test_reset_state();
    test_text_cases();
    test_binary_words();
    test_short_values();
    test_backpressure();
    test_random_reads(370);

    src_idle_pct  = 65;
    sink_idle_pct = 14;
    test_random_reads(370);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_reads(370);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/aisp_pkg.sv
hw/rtl/aisp_if.sv
hw/rtl/ascii_integer_stream_parser.sv
sim/ascii_integer_stream_parser_tb.sv
